### sv/assert_macros.svh
// Assertion macros used by segment_intersection.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/sgi_pkg.sv
// Package with constants and types of the segment intersection block.
`default_nettype none
package sgi_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 31;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int TQ_W      = FRAC_BITS + 1;
  localparam int MUL_W     = TQ_W + 1 + DIFF_W;
  localparam int NUM_STG   = FRAC_BITS + 6;
  localparam int STG_DIV0  = 4;
  localparam int STG_MUL   = STG_DIV0 + FRAC_BITS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    logic   hit;
    logic   full;
    coord_t ax0;
    coord_t ay0;
    diff_t  dax;
    diff_t  day;
  } ctx_t;
endpackage
`default_nettype wire

### sv/sgi_if.sv
// Channel interfaces for segment pairs and intersection results.
`default_nettype none
interface sgi_in_if;
  import sgi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t a_start_x;
  coord_t a_start_y;
  coord_t a_end_x;
  coord_t a_end_y;
  coord_t b_start_x;
  coord_t b_start_y;
  coord_t b_end_x;
  coord_t b_end_y;
  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sgi_out_if;
  import sgi_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t cross_x;
  coord_t cross_y;
  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

### sv/segment_intersection.sv
// Stages: differences, products, cross products, range tests, restoring divider, scale, output.
// One transaction per cycle unless output stalls; the divider has one stage per quotient bit.
// Each stage holds its item until the next stage frees, so stalls fill bubbles and drop nothing.
// Reset (synchronous, rst_n low) empties every stage; payload registers are not reset.
`default_nettype none
module segment_intersection (
  input  wire         clk,
  input  wire         rst_n,
  sgi_in_if.sink      in_ch,
  sgi_out_if.source   out_ch
);
  import sgi_pkg::*;
  `include "assert_macros.svh"

  logic [NUM_STG-1:0] v_r;
  logic [NUM_STG-1:0] adv;
  ctx_t               ctx_r [NUM_STG-1];

  diff_t dbx_r, dby_r, ox_r, oy_r;
  prod_t p_den_a_r, p_den_b_r, p_s_a_r, p_s_b_r, p_t_a_r, p_t_b_r;
  prod_t den_r, snum_r, tnum_r;

  logic [PROD_W-1:0]    rem_r [FRAC_BITS+1];
  logic [PROD_W-1:0]    dv_r  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_r   [FRAC_BITS+1];

  logic signed [MUL_W-1:0] mx_r, my_r;
  logic   hit_r;
  coord_t cross_x_r, cross_y_r;

  always_comb begin
    adv[NUM_STG-1] = !v_r[NUM_STG-1] || out_ch.ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // stage 0: differences
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ctx_r[0].hit  <= 1'b0;
      ctx_r[0].full <= 1'b0;
      ctx_r[0].ax0  <= in_ch.a_start_x;
      ctx_r[0].ay0  <= in_ch.a_start_y;
      ctx_r[0].dax  <= DIFF_W'(in_ch.a_end_x) - DIFF_W'(in_ch.a_start_x);
      ctx_r[0].day  <= DIFF_W'(in_ch.a_end_y) - DIFF_W'(in_ch.a_start_y);
      dbx_r <= DIFF_W'(in_ch.b_end_x) - DIFF_W'(in_ch.b_start_x);
      dby_r <= DIFF_W'(in_ch.b_end_y) - DIFF_W'(in_ch.b_start_y);
      ox_r  <= DIFF_W'(in_ch.a_start_x) - DIFF_W'(in_ch.b_start_x);
      oy_r  <= DIFF_W'(in_ch.a_start_y) - DIFF_W'(in_ch.b_start_y);
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ctx_r[1]  <= ctx_r[0];
      p_den_a_r <= PROD_W'(ctx_r[0].dax) * PROD_W'(dby_r);
      p_den_b_r <= PROD_W'(dbx_r) * PROD_W'(ctx_r[0].day);
      p_s_a_r   <= PROD_W'(ctx_r[0].dax) * PROD_W'(oy_r);
      p_s_b_r   <= PROD_W'(ctx_r[0].day) * PROD_W'(ox_r);
      p_t_a_r   <= PROD_W'(dbx_r) * PROD_W'(oy_r);
      p_t_b_r   <= PROD_W'(dby_r) * PROD_W'(ox_r);
    end
  end

  // stage 2: cross products
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ctx_r[2] <= ctx_r[1];
      den_r    <= p_den_a_r - p_den_b_r;
      snum_r   <= p_s_a_r - p_s_b_r;
      tnum_r   <= p_t_a_r - p_t_b_r;
    end
  end

  // stage 3: range tests and magnitudes
  logic              s_ok, t_ok, hit_nxt;
  logic [PROD_W-1:0] n_mag, d_mag;
  ctx_t              ctx3_nxt;

  always_comb begin
    if (den_r > 0) begin
      s_ok = (snum_r >= 0) && (snum_r <= den_r);
      t_ok = (tnum_r >= 0) && (tnum_r <= den_r);
    end else begin
      s_ok = (snum_r <= 0) && (snum_r >= den_r);
      t_ok = (tnum_r <= 0) && (tnum_r >= den_r);
    end
    hit_nxt = (den_r != 0) && s_ok && t_ok;
    n_mag   = tnum_r[PROD_W-1] ? PROD_W'(-tnum_r) : PROD_W'(tnum_r);
    d_mag   = den_r[PROD_W-1] ? PROD_W'(-den_r) : PROD_W'(den_r);
    ctx3_nxt      = ctx_r[2];
    ctx3_nxt.hit  = hit_nxt;
    ctx3_nxt.full = n_mag >= d_mag;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ctx_r[3]      <= ctx3_nxt;
      rem_r[0]      <= n_mag;
      dv_r[0]       <= d_mag;
      q_r[0]        <= '0;
    end
  end

  // divider: one quotient bit per stage
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [PROD_W:0] r2;
    logic            ge;
    assign r2 = {rem_r[k], 1'b0};
    assign ge = r2 >= {1'b0, dv_r[k]};
    always_ff @(posedge clk) begin
      if (adv[STG_DIV0+k]) begin
        ctx_r[STG_DIV0+k] <= ctx_r[STG_DIV0+k-1];
        rem_r[k+1] <= ge ? PROD_W'(r2 - {1'b0, dv_r[k]}) : PROD_W'(r2);
        dv_r[k+1]  <= dv_r[k];
        q_r[k+1]   <= {q_r[k][FRAC_BITS-2:0], ge};
      end
    end
  end

  // scale step
  logic [TQ_W-1:0] tq;
  assign tq = ctx_r[STG_MUL-1].full ? TQ_W'(1) << FRAC_BITS : {1'b0, q_r[FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (adv[STG_MUL]) begin
      ctx_r[STG_MUL] <= ctx_r[STG_MUL-1];
      mx_r <= $signed({1'b0, tq}) * ctx_r[STG_MUL-1].dax;
      my_r <= $signed({1'b0, tq}) * ctx_r[STG_MUL-1].day;
    end
  end

  // output register
  logic signed [MUL_W-1:0] sum_x, sum_y;
  assign sum_x = (mx_r >>> FRAC_BITS) + MUL_W'(ctx_r[STG_MUL].ax0);
  assign sum_y = (my_r >>> FRAC_BITS) + MUL_W'(ctx_r[STG_MUL].ay0);

  always_ff @(posedge clk) begin
    if (adv[NUM_STG-1]) begin
      hit_r     <= ctx_r[STG_MUL].hit;
      cross_x_r <= ctx_r[STG_MUL].hit ? sum_x[COORD_W-1:0] : '0;
      cross_y_r <= ctx_r[STG_MUL].hit ? sum_y[COORD_W-1:0] : '0;
    end
  end

  assign out_ch.valid   = v_r[NUM_STG-1];
  assign out_ch.hit     = hit_r;
  assign out_ch.cross_x = cross_x_r;
  assign out_ch.cross_y = cross_y_r;

  `ASSERT_IMPL(a_miss_zero, clk, rst_n, out_ch.valid && !out_ch.hit,
    out_ch.cross_x == '0 && out_ch.cross_y == '0, "miss with nonzero point")
  `ASSERT_IMPL(a_stall_full, clk, rst_n, !in_ch.ready,
    out_ch.valid && !out_ch.ready && (&v_r), "input stalled with free stage")
  `ASSERT_IMPL(a_div_bound, clk, rst_n, v_r[STG_MUL-1] && ctx_r[STG_MUL-1].hit,
    rem_r[FRAC_BITS] < dv_r[FRAC_BITS] || ctx_r[STG_MUL-1].full,
    "divider remainder not below divisor")
endmodule
`default_nettype wire

### sim/tb_sgi_if.sv
// Testbench copy note: channel interfaces come from the RTL; this file holds shared test types.
`timescale 1ns / 1ps
package tb_sgi_pkg;
  import sgi_pkg::*;

  typedef struct packed {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct packed {
    logic   hit;
    coord_t cx;
    coord_t cy;
  } crossing_t;
endpackage

### sim/tb_segment_intersection.sv
// Testbench for segment_intersection: directed table plus random segment pairs, scoreboarded.
`timescale 1ns / 1ps
module tb_segment_intersection;
  import sgi_pkg::*;
  import tb_sgi_pkg::*;

  localparam int LATENCY = FRAC_BITS + 6;
  localparam int NUM_RAND = 850;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sgi_in_if  in_ch();
  sgi_out_if out_ch();

  segment_intersection dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  crossing_t pending_crossings[$];
  int        mismatch_cnt = 0;
  bit        send_done = 1'b0;
  bit        quiet_sink = 1'b0;

  typedef struct {
    seg_pair_t pair;
    bit        typed;
    crossing_t want;
  } dir_row_t;

  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    longint dax, day, dbx, dby, ox, oy, den, snum, tnum, tq, px, py;
    longint unsigned rem, dmag;
    bit s_ok, t_ok;
    r = '0;
    dax = longint'(p.ax1) - longint'(p.ax0);
    day = longint'(p.ay1) - longint'(p.ay0);
    dbx = longint'(p.bx1) - longint'(p.bx0);
    dby = longint'(p.by1) - longint'(p.by0);
    ox  = longint'(p.ax0) - longint'(p.bx0);
    oy  = longint'(p.ay0) - longint'(p.by0);
    den  = dax * dby - dbx * day;
    snum = dax * oy - day * ox;
    tnum = dbx * oy - dby * ox;
    if (den == 0) return r;
    if (den > 0) begin
      s_ok = snum >= 0 && snum <= den;
      t_ok = tnum >= 0 && tnum <= den;
    end else begin
      s_ok = snum <= 0 && snum >= den;
      t_ok = tnum <= 0 && tnum >= den;
    end
    if (!(s_ok && t_ok)) return r;
    rem  = tnum < 0 ? -tnum : tnum;
    dmag = den < 0 ? -den : den;
    if (rem >= dmag) begin
      tq = longint'(1) <<< FRAC_BITS;
    end else begin
      tq = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        tq = tq <<< 1;
        if (rem >= dmag) begin
          rem -= dmag;
          tq |= 1;
        end
      end
    end
    px = longint'(p.ax0) + ((tq * dax) >>> FRAC_BITS);
    py = longint'(p.ay0) + ((tq * day) >>> FRAC_BITS);
    r.hit = 1'b1;
    r.cx = coord_t'(px);
    r.cy = coord_t'(py);
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
      default: return coord_t'($urandom_range(0, 1 << 22)) - coord_t'(1 << 21);
    endcase
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int mode;
    int kind;
    mode = $urandom_range(0, 2);
    p.ax0 = rand_coord(mode); p.ay0 = rand_coord(mode);
    p.ax1 = rand_coord(mode); p.ay1 = rand_coord(mode);
    p.bx0 = rand_coord(mode); p.by0 = rand_coord(mode);
    p.bx1 = rand_coord(mode); p.by1 = rand_coord(mode);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      p.bx1 = p.bx0 + (p.ax1 - p.ax0);
      p.by1 = p.by0 + (p.ay1 - p.ay0);
    end else if (kind == 1) begin
      p.bx0 = p.ax1; p.by0 = p.ay1;
    end else if (kind <= 5 && mode != 0) begin
      // aim for a crossing: B is centred on the truncated midpoint of A
      p.bx1 = 2 * (p.ax0 + (p.ax1 - p.ax0) / 2) - p.bx0;
      p.by1 = 2 * (p.ay0 + (p.ay1 - p.ay0) / 2) - p.by0;
    end
    return p;
  endfunction

  function automatic bit idle_roll(bit quiet);
    return !quiet && ($urandom_range(0, 99) < 37);
  endfunction

  task automatic send_pair(seg_pair_t p, crossing_t want, bit quiet);
    while (idle_roll(quiet)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.a_start_x <= p.ax0; in_ch.a_start_y <= p.ay0;
    in_ch.a_end_x   <= p.ax1; in_ch.a_end_y   <= p.ay1;
    in_ch.b_start_x <= p.bx0; in_ch.b_start_y <= p.by0;
    in_ch.b_end_x   <= p.bx1; in_ch.b_end_y   <= p.by1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_crossings.push_back(want);
  endtask

  task automatic check_crossing(crossing_t got, crossing_t want);
    if (got !== want) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch: want hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                 want.hit, want.cx, want.cy, got.hit, got.cx, got.cy);
    end
  endtask

  localparam coord_t CMAX = 31'sh3FFF_FFFF;
  localparam coord_t CMIN = -31'sh4000_0000;
  localparam coord_t ONE  = 31'sh0001_0000;

  dir_row_t dir_rows[] = '{
    '{'{ONE*0, ONE*0, ONE*2, ONE*2, ONE*0, ONE*2, ONE*2, ONE*0}, 1'b1, '{1'b1, ONE, ONE}},
    '{'{ONE*0, ONE*0, ONE*2, ONE*0, ONE*0, ONE*1, ONE*2, ONE*1}, 1'b1, '{1'b0, 0, 0}},
    '{'{ONE*0, ONE*0, ONE*2, ONE*0, ONE*1, ONE*0, ONE*3, ONE*0}, 1'b1, '{1'b0, 0, 0}},
    '{'{ONE*1, ONE*1, ONE*1, ONE*1, ONE*0, ONE*0, ONE*2, ONE*2}, 1'b1, '{1'b0, 0, 0}},
    '{'{ONE*0, ONE*0, ONE*2, ONE*0, ONE*2, ONE*0, ONE*2, ONE*3}, 1'b1, '{1'b1, ONE*2, 0}},
    '{'{ONE*0, ONE*0, ONE*2, ONE*0, ONE*0, ONE*0, ONE*0, ONE*3}, 1'b1, '{1'b1, 0, 0}},
    '{'{ONE*0, ONE*0, ONE*2, ONE*0, ONE*3, -ONE, ONE*3, ONE*1}, 1'b1, '{1'b0, 0, 0}},
    '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, '{1'b0, 0, 0}},
    '{'{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b0, '{1'b0, 0, 0}},
    '{'{CMIN, CMIN, CMIN, CMAX, CMIN, ONE, CMAX, ONE}, 1'b0, '{1'b0, 0, 0}},
    '{'{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN}, 1'b1, '{1'b0, 0, 0}},
    '{'{CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX}, 1'b0, '{1'b0, 0, 0}},
    '{'{-ONE*3, 31'sd7, ONE*5, -31'sd13, ONE, -ONE*4, -ONE, ONE*4}, 1'b0, '{1'b0, 0, 0}},
    '{'{31'sd1, 31'sd0, 31'sd4, 31'sd3, 31'sd0, 31'sd3, 31'sd3, 31'sd0}, 1'b0, '{1'b0, 0, 0}},
    '{'{-31'sd5, -31'sd5, 31'sd7, 31'sd2, 31'sd3, -31'sd9, -31'sd1, 31'sd8}, 1'b0, '{1'b0, 0, 0}}
  };

  initial begin
    seg_pair_t rp;
    in_ch.valid <= 1'b0;
    in_ch.a_start_x <= '0; in_ch.a_start_y <= '0; in_ch.a_end_x <= '0; in_ch.a_end_y <= '0;
    in_ch.b_start_x <= '0; in_ch.b_start_y <= '0; in_ch.b_end_x <= '0; in_ch.b_end_y <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].pair,
                dir_rows[i].typed ? dir_rows[i].want : predict_crossing(dir_rows[i].pair),
                1'b0);
    end
    in_ch.valid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    for (int n = 0; n < NUM_RAND; n++) begin
      quiet_sink <= (n >= 300 && n < 420);
      rp = rand_pair();
      send_pair(rp, predict_crossing(rp), n >= 300 && n < 420);
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_sink || ($urandom_range(0, 99) >= 37);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_crossings.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result transaction");
        end else begin
          check_crossing('{out_ch.hit, out_ch.cross_x, out_ch.cross_y},
                         pending_crossings.pop_front());
        end
      end
    end
  end

  initial begin
    wait (send_done);
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_crossings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
